// ----- rtl/lprt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the lidar point rigid transform block.
package lprt_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int CURV_FRAC_BITS_DFLT = 16;

    // Rotation coefficients are signed Q2.30
    localparam int COEF_FRAC = 30;
    localparam int NUM_COEF = 9;
    typedef logic signed [32:0] coef_t;
    localparam coef_t COEF_ONE = 33'sd1 <<< COEF_FRAC;

    localparam logic signed [15:0] QUAT_W_RST = 16'(64'd1 << QUAT_FRAC_BITS);

    // Register map (word index)
    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_TRANS_X = 3'd1;
    localparam logic [2:0] REG_TRANS_Y = 3'd2;
    localparam logic [2:0] REG_TRANS_Z = 3'd3;
    localparam logic [2:0] REG_QUAT_W  = 3'd4;
    localparam logic [2:0] REG_QUAT_X  = 3'd5;
    localparam logic [2:0] REG_QUAT_Y  = 3'd6;
    localparam logic [2:0] REG_QUAT_Z  = 3'd7;

    // Reflectivity fraction: floor((r * 2^20 + 312) / 625) by reciprocal multiply
    localparam logic [28:0] INT_BIAS  = 29'd312;
    localparam logic [29:0] INT_RECIP = 30'd879609303;
    localparam int INT_SHIFT = 39;

    // Curvature quotient carries one bit beyond the 16-bit output to flag saturation
    localparam int CURV_QBITS = 17;

endpackage

// ----- rtl/lprt_coef.sv -----
`timescale 1ns / 1ps
// Sequencer that turns the pose quaternion into a normalized Q2.30 rotation matrix.
module lprt_coef
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [15:0]        quat_w,
    input  logic signed [15:0]        quat_x,
    input  logic signed [15:0]        quat_y,
    input  logic signed [15:0]        quat_z,
    output logic                      busy,
    output lprt_pkg::coef_t           rot [lprt_pkg::NUM_COEF]
);
    import lprt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROD  = 3'd1;
    localparam logic [2:0] ST_NORM  = 3'd2;
    localparam logic [2:0] ST_MENT  = 3'd3;
    localparam logic [2:0] ST_DINIT = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_STORE = 3'd6;

    logic [2:0]          state_reg;
    logic [3:0]          idx_reg;
    logic [4:0]          cnt_reg;
    logic signed [31:0]  ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [31:0]  wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic [32:0]         n_reg;
    logic signed [34:0]  m_reg;
    logic                neg_reg;
    logic [32:0]         rem_reg;
    logic [31:0]         low_reg;
    logic [31:0]         q_reg;
    coef_t               rot_reg [NUM_COEF];

    logic [32:0]         n_next;
    logic signed [34:0]  m_next;
    logic [34:0]         mag_c;
    logic [62:0]         dvd_c;
    logic [33:0]         trial_c;
    logic [33:0]         diff_c;
    logic                ge_c;

    always_comb
    begin
        n_next = 33'($unsigned(ww_reg)) + 33'($unsigned(xx_reg))
               + 33'($unsigned(yy_reg)) + 33'($unsigned(zz_reg));
    end

    always_comb
    begin
        unique case (idx_reg)
            4'd0: m_next = 35'(ww_reg) + 35'(xx_reg) - 35'(yy_reg) - 35'(zz_reg);
            4'd1: m_next = (35'(xy_reg) - 35'(wz_reg)) <<< 1;
            4'd2: m_next = (35'(xz_reg) + 35'(wy_reg)) <<< 1;
            4'd3: m_next = (35'(xy_reg) + 35'(wz_reg)) <<< 1;
            4'd4: m_next = 35'(ww_reg) - 35'(xx_reg) + 35'(yy_reg) - 35'(zz_reg);
            4'd5: m_next = (35'(yz_reg) - 35'(wx_reg)) <<< 1;
            4'd6: m_next = (35'(xz_reg) - 35'(wy_reg)) <<< 1;
            4'd7: m_next = (35'(yz_reg) + 35'(wx_reg)) <<< 1;
            4'd8: m_next = 35'(ww_reg) - 35'(xx_reg) - 35'(yy_reg) + 35'(zz_reg);
            default: m_next = '0;
        endcase
    end

    always_comb
    begin
        mag_c   = m_reg[34] ? 35'(-m_reg) : 35'(m_reg);
        // magnitude scaled by 2^30, plus half the norm for rounding
        dvd_c   = {mag_c[32:0], 30'b0} + 63'(n_reg >> 1);
        trial_c = {rem_reg, low_reg[31]};
        ge_c    = trial_c >= {1'b0, n_reg};
        diff_c  = trial_c - {1'b0, n_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            for (int k = 0; k < NUM_COEF; k++)
            begin
                rot_reg[k] <= (k % 4 == 0) ? COEF_ONE : '0;
            end
        end
        else if (start)
        begin
            state_reg <= ST_PROD;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_PROD:
                begin
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    if (n_next == '0)
                    begin
                        // zero quaternion: identity rotation
                        for (int k = 0; k < NUM_COEF; k++)
                        begin
                            rot_reg[k] <= (k % 4 == 0) ? COEF_ONE : '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MENT;
                    end
                end
                ST_MENT:
                begin
                    state_reg <= ST_DINIT;
                end
                ST_DINIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    rot_reg[idx_reg] <= neg_reg ? coef_t'(-$signed({1'b0, q_reg}))
                                                : coef_t'($signed({1'b0, q_reg}));
                    if (idx_reg == 4'(NUM_COEF - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= ST_MENT;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PROD)
        begin
            ww_reg <= quat_w * quat_w;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            wz_reg <= quat_w * quat_z;
            xz_reg <= quat_x * quat_z;
            wy_reg <= quat_w * quat_y;
            yz_reg <= quat_y * quat_z;
            wx_reg <= quat_w * quat_x;
        end
        if (state_reg == ST_NORM)
        begin
            n_reg <= n_next;
        end
        if (state_reg == ST_MENT)
        begin
            m_reg <= m_next;
        end
        if (state_reg == ST_DINIT)
        begin
            neg_reg <= m_reg[34];
            rem_reg <= 33'(dvd_c[62:32]);
            low_reg <= dvd_c[31:0];
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= ge_c ? diff_c[32:0] : trial_c[32:0];
            low_reg <= {low_reg[30:0], 1'b0};
            q_reg   <= {q_reg[30:0], ge_c};
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign rot  = rot_reg;

endmodule

// ----- rtl/lidar_point_rigid_transform_unit.sv -----
`timescale 1ns / 1ps
// Pipeline from input word to output register; one word per cycle unless the output stalls or the matrix rebuilds.
// The curvature divider retires 6, 6 and 5 quotient bits in the last three stages.
// A quaternion write rebuilds the rotation matrix; input ready stays low meanwhile.
// Reset: enable 0, translation 0, identity quaternion and matrix, pipeline empty.
// Output stage holds its word under backpressure; upstream stages fill bubbles.
module lidar_point_rigid_transform_unit
#(
    parameter int CURV_FRAC_BITS = lprt_pkg::CURV_FRAC_BITS_DFLT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [31:0]        time_offset,
    input  logic [7:0]         scan_line,
    input  logic [7:0]         reflect,
    input  logic [31:0]        frame_end_offset,
    input  logic               cloud_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [31:0]        intensity,
    output logic [15:0]        curvature,
    output logic               out_last
);
    import lprt_pkg::*;

    localparam int NW = 33 + CURV_FRAC_BITS;

    // configuration
    logic               en_reg;
    logic signed [31:0] trans_reg [3];
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic               cfg_wr;
    logic               coef_start;
    logic               coef_busy;
    coef_t              rot [NUM_COEF];

    // stage valids and advance
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic accept;

    logic signed [31:0] vin [3];

    // stage 1
    logic signed [48:0] pph_reg [NUM_COEF];
    logic signed [49:0] ppl_reg [NUM_COEF];
    logic [NW-1:0]      cvn1_reg;
    logic [35:0]        cvd1_reg;
    logic               cvz1_reg;
    logic [58:0]        iprod1_reg;
    logic [7:0]         line1_reg;
    logic signed [31:0] pos1_reg [3];
    logic               last1_reg;
    logic [34:0]        tend5_c;
    logic [28:0]        ia_c;

    // stage 2
    logic signed [50:0] rsh2_reg [3];
    logic signed [51:0] rsl2_reg [3];
    logic               ovf2_reg, cvz2_reg;
    logic [35:0]        rem2_reg, cvd2_reg;
    logic [CURV_QBITS-1:0] low2_reg;
    logic [31:0]        inten2_reg;
    logic signed [31:0] pos2_reg [3];
    logic               last2_reg;
    logic [NW-18:0]     nhi_c;

    // stage 3
    logic signed [67:0] acc3_reg [3];
    logic               ovf3_reg, cvz3_reg;
    logic [35:0]        rem3_reg, cvd3_reg;
    logic [10:0]        low3_reg;
    logic [5:0]         q3_reg;
    logic [31:0]        inten3_reg;
    logic signed [31:0] pos3_reg [3];
    logic               last3_reg;
    logic [35:0]        rem3_next;
    logic [5:0]         q3_next;

    // stage 4
    logic signed [37:0] rnd4_reg [3];
    logic               ovf4_reg, cvz4_reg;
    logic [35:0]        rem4_reg, cvd4_reg;
    logic [4:0]         low4_reg;
    logic [11:0]        q4_reg;
    logic [31:0]        inten4_reg;
    logic signed [31:0] pos4_reg [3];
    logic               last4_reg;
    logic [35:0]        rem4_next;
    logic [5:0]         q4_next;
    logic signed [67:0] rt_c [3];

    // stage 5 (output)
    logic signed [31:0] o5_reg [3];
    logic [31:0]        inten5_reg;
    logic [15:0]        curv5_reg;
    logic               last5_reg;
    logic [4:0]         q5_next;
    logic [CURV_QBITS-1:0] qf_c;
    logic signed [38:0] tsum_c [3];
    logic signed [31:0] o5_next [3];

    // ---------------- configuration port ----------------
    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign coef_start = cfg_wr & paddr[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg       <= 1'b0;
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
            qw_reg       <= QUAT_W_RST;
            qx_reg       <= '0;
            qy_reg       <= '0;
            qz_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_ENABLE:  en_reg       <= pwdata[0];
                REG_TRANS_X: trans_reg[0] <= pwdata;
                REG_TRANS_Y: trans_reg[1] <= pwdata;
                REG_TRANS_Z: trans_reg[2] <= pwdata;
                REG_QUAT_W:  qw_reg       <= pwdata[15:0];
                REG_QUAT_X:  qx_reg       <= pwdata[15:0];
                REG_QUAT_Y:  qy_reg       <= pwdata[15:0];
                REG_QUAT_Z:  qz_reg       <= pwdata[15:0];
                default:     en_reg       <= en_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ENABLE:  prdata = {31'b0, en_reg};
            REG_TRANS_X: prdata = trans_reg[0];
            REG_TRANS_Y: prdata = trans_reg[1];
            REG_TRANS_Z: prdata = trans_reg[2];
            REG_QUAT_W:  prdata = {16'b0, qw_reg};
            REG_QUAT_X:  prdata = {16'b0, qx_reg};
            REG_QUAT_Y:  prdata = {16'b0, qy_reg};
            REG_QUAT_Z:  prdata = {16'b0, qz_reg};
            default:     prdata = '0;
        endcase
    end

    lprt_coef u_coef
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (coef_start),
        .quat_w (qw_reg),
        .quat_x (qx_reg),
        .quat_y (qy_reg),
        .quat_z (qz_reg),
        .busy   (coef_busy),
        .rot    (rot)
    );

    // ---------------- pipeline control ----------------
    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1 && !coef_busy;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= accept;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    assign vin[0] = pos_x;
    assign vin[1] = pos_y;
    assign vin[2] = pos_z;

    // ---------------- stage 1: partial products, divider operands ----------------
    always_comb
    begin
        tend5_c = 35'({frame_end_offset, 2'b00}) + 35'(frame_end_offset);
        ia_c    = {1'b0, reflect, 20'b0} + INT_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pph_reg[3*i+j] <= rot[3*i+j] * $signed(vin[j][31:16]);
                    ppl_reg[3*i+j] <= rot[3*i+j] * $signed({1'b0, vin[j][15:0]});
                end
            end
            cvn1_reg   <= NW'({time_offset, {CURV_FRAC_BITS{1'b0}}}) + NW'(tend5_c);
            cvd1_reg   <= {tend5_c, 1'b0};
            cvz1_reg   <= (frame_end_offset == '0);
            iprod1_reg <= 59'(ia_c) * 59'(INT_RECIP);
            line1_reg  <= scan_line;
            pos1_reg   <= vin;
            last1_reg  <= cloud_last;
        end
    end

    // ---------------- stage 2: row sums, divider setup, intensity ----------------
    assign nhi_c = cvn1_reg[NW-1:CURV_QBITS];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsh2_reg[i] <= 51'(pph_reg[3*i]) + 51'(pph_reg[3*i+1]) + 51'(pph_reg[3*i+2]);
                rsl2_reg[i] <= 52'(ppl_reg[3*i]) + 52'(ppl_reg[3*i+1]) + 52'(ppl_reg[3*i+2]);
            end
            // quotient would need more than CURV_QBITS bits
            ovf2_reg   <= NW'(nhi_c) >= NW'(cvd1_reg);
            rem2_reg   <= 36'(nhi_c);
            low2_reg   <= cvn1_reg[CURV_QBITS-1:0];
            cvd2_reg   <= cvd1_reg;
            cvz2_reg   <= cvz1_reg;
            inten2_reg <= {line1_reg, 24'b0} + 32'(iprod1_reg[58:INT_SHIFT]);
            pos2_reg   <= pos1_reg;
            last2_reg  <= last1_reg;
        end
    end

    // ---------------- stage 3: accumulate, divider bits 16..11 ----------------
    always_comb
    begin
        logic [36:0] t;
        logic [35:0] r;
        logic [5:0]  q;
        r = rem2_reg;
        q = '0;
        for (int k = 0; k < 6; k++)
        begin
            t = {r, low2_reg[16-k]};
            if (t >= {1'b0, cvd2_reg})
            begin
                t = t - {1'b0, cvd2_reg};
                q = {q[4:0], 1'b1};
            end
            else
            begin
                q = {q[4:0], 1'b0};
            end
            r = t[35:0];
        end
        rem3_next = r;
        q3_next   = q;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc3_reg[i] <= (68'(rsh2_reg[i]) <<< 16) + 68'(rsl2_reg[i]);
            end
            ovf3_reg   <= ovf2_reg;
            cvz3_reg   <= cvz2_reg;
            rem3_reg   <= rem3_next;
            cvd3_reg   <= cvd2_reg;
            low3_reg   <= low2_reg[10:0];
            q3_reg     <= q3_next;
            inten3_reg <= inten2_reg;
            pos3_reg   <= pos2_reg;
            last3_reg  <= last2_reg;
        end
    end

    // ---------------- stage 4: round, divider bits 10..5 ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // half away from zero: bias one less for negative sums
            rt_c[i] = acc3_reg[i] + (acc3_reg[i][67] ? 68'sd536870911 : 68'sd536870912);
        end
    end

    always_comb
    begin
        logic [36:0] t;
        logic [35:0] r;
        logic [5:0]  q;
        r = rem3_reg;
        q = '0;
        for (int k = 0; k < 6; k++)
        begin
            t = {r, low3_reg[10-k]};
            if (t >= {1'b0, cvd3_reg})
            begin
                t = t - {1'b0, cvd3_reg};
                q = {q[4:0], 1'b1};
            end
            else
            begin
                q = {q[4:0], 1'b0};
            end
            r = t[35:0];
        end
        rem4_next = r;
        q4_next   = q;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd4_reg[i] <= rt_c[i][67:COEF_FRAC];
            end
            ovf4_reg   <= ovf3_reg;
            cvz4_reg   <= cvz3_reg;
            rem4_reg   <= rem4_next;
            cvd4_reg   <= cvd3_reg;
            low4_reg   <= low3_reg[4:0];
            q4_reg     <= {q3_reg, q4_next};
            inten4_reg <= inten3_reg;
            pos4_reg   <= pos3_reg;
            last4_reg  <= last3_reg;
        end
    end

    // ---------------- stage 5: translate, saturate, divider bits 4..0 ----------------
    always_comb
    begin
        logic [36:0] t;
        logic [35:0] r;
        logic [4:0]  q;
        r = rem4_reg;
        q = '0;
        for (int k = 0; k < 5; k++)
        begin
            t = {r, low4_reg[4-k]};
            if (t >= {1'b0, cvd4_reg})
            begin
                t = t - {1'b0, cvd4_reg};
                q = {q[3:0], 1'b1};
            end
            else
            begin
                q = {q[3:0], 1'b0};
            end
            r = t[35:0];
        end
        q5_next = q;
        qf_c    = {q4_reg, q5_next};
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tsum_c[i] = 39'(rnd4_reg[i]) + 39'(trans_reg[i]);
            if (!en_reg)
            begin
                o5_next[i] = pos4_reg[i];
            end
            else if (tsum_c[i][38] && !(&tsum_c[i][37:31]))
            begin
                o5_next[i] = 32'sh8000_0000;
            end
            else if (!tsum_c[i][38] && (|tsum_c[i][37:31]))
            begin
                o5_next[i] = 32'sh7fff_ffff;
            end
            else
            begin
                o5_next[i] = tsum_c[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            o5_reg     <= o5_next;
            inten5_reg <= inten4_reg;
            last5_reg  <= last4_reg;
            if (cvz4_reg)
            begin
                curv5_reg <= '0;
            end
            else if (ovf4_reg || qf_c[CURV_QBITS-1])
            begin
                curv5_reg <= '1;
            end
            else
            begin
                curv5_reg <= qf_c[15:0];
            end
        end
    end

    assign out_valid = v5_reg;
    assign out_x     = o5_reg[0];
    assign out_y     = o5_reg[1];
    assign out_z     = o5_reg[2];
    assign intensity = inten5_reg;
    assign curvature = curv5_reg;
    assign out_last  = last5_reg;

    // ---------------- assertions ----------------
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        coef_busy |-> !in_ready)
        else $error("input accepted while rotation matrix rebuilds");

    a_div_rem_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ovf2_reg && !cvz2_reg) |-> (rem2_reg < cvd2_reg))
        else $error("curvature divider remainder out of range at stage 2");

    a_div_rem_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !ovf3_reg && !cvz3_reg) |-> (rem3_reg < cvd3_reg))
        else $error("curvature divider remainder out of range at stage 3");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && v5_reg && !out_ready) |=> v4_reg)
        else $error("word dropped behind stalled output");

endmodule

// ----- test/lidar_point_rigid_transform_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the lidar point rigid transform unit.
module lidar_point_rigid_transform_unit_tb;
    import lprt_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        inten;
        logic [15:0]        curv;
        logic               last;
    } point_out_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        toff;
        logic [7:0]         line;
        logic [7:0]         refl;
        logic [31:0]        tend;
        logic               last;
    } point_in_t;

    class point_scoreboard;
        bit                 en;
        logic signed [63:0] trans [3];
        logic signed [63:0] quat [4];
        point_out_t         pending [$];
        int                 errors;

        function new();
            en = 0;
            foreach (trans[i]) trans[i] = 0;
            quat[0] = QUAT_W_RST;
            quat[1] = 0;
            quat[2] = 0;
            quat[3] = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_ENABLE:  en = val[0];
                REG_TRANS_X: trans[0] = $signed(val);
                REG_TRANS_Y: trans[1] = $signed(val);
                REG_TRANS_Z: trans[2] = $signed(val);
                REG_QUAT_W:  quat[0] = $signed(val[15:0]);
                REG_QUAT_X:  quat[1] = $signed(val[15:0]);
                REG_QUAT_Y:  quat[2] = $signed(val[15:0]);
                default:     quat[3] = $signed(val[15:0]);
            endcase
        endfunction

        // round half away from zero
        function logic signed [127:0] round_div(logic signed [127:0] num,
                                                logic signed [127:0] den);
            logic signed [127:0] a;
            logic signed [127:0] q;
            a = (num < 0) ? -num : num;
            q = (a + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function void note_point(point_in_t p);
            point_out_t          e;
            logic signed [127:0] w, x, y, z, n, acc, s;
            logic signed [127:0] m [9];
            logic signed [127:0] r [9];
            logic signed [127:0] v [3];
            logic signed [127:0] o [3];
            logic [63:0]         d, c;
            v[0] = p.x;
            v[1] = p.y;
            v[2] = p.z;
            e.x = p.x;
            e.y = p.y;
            e.z = p.z;
            if (en) begin
                w = quat[0];
                x = quat[1];
                y = quat[2];
                z = quat[3];
                n = w * w + x * x + y * y + z * z;
                m[0] = w * w + x * x - y * y - z * z;
                m[1] = 2 * (x * y - w * z);
                m[2] = 2 * (x * z + w * y);
                m[3] = 2 * (x * y + w * z);
                m[4] = w * w - x * x + y * y - z * z;
                m[5] = 2 * (y * z - w * x);
                m[6] = 2 * (x * z - w * y);
                m[7] = 2 * (y * z + w * x);
                m[8] = w * w - x * x - y * y + z * z;
                for (int k = 0; k < 9; k++)
                    if (n == 0)
                        r[k] = (k % 4 == 0) ? (128'sd1 <<< 30) : 0;
                    else
                        r[k] = round_div(m[k] * (128'sd1 <<< 30), n);
                for (int i = 0; i < 3; i++)
                begin
                    acc = r[3*i] * v[0] + r[3*i+1] * v[1] + r[3*i+2] * v[2];
                    s = round_div(acc, 128'sd1 <<< 30) + trans[i];
                    if (s > 128'sd2147483647) s = 128'sd2147483647;
                    if (s < -128'sd2147483648) s = -128'sd2147483648;
                    o[i] = s;
                end
                e.x = o[0][31:0];
                e.y = o[1][31:0];
                e.z = o[2][31:0];
            end
            e.inten = 32'(({24'd0, p.line} << 24)
                    + (({40'd0, p.refl} << 24) + 64'd5000) / 64'd10000);
            if (p.tend == 0)
                e.curv = 0;
            else
            begin
                d = 64'(p.tend) * 10;
                c = ((64'(p.toff) << 16) + d / 2) / d;
                e.curv = (c > 64'hFFFF) ? 16'hFFFF : c[15:0];
            end
            e.last = p.last;
            pending = {pending, e};
        endfunction

        function void check_point(point_out_t a);
            point_out_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected output word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.x !== e.x) begin $error("out_x exp %0d got %0d", e.x, a.x); errors++; end
            if (a.y !== e.y) begin $error("out_y exp %0d got %0d", e.y, a.y); errors++; end
            if (a.z !== e.z) begin $error("out_z exp %0d got %0d", e.z, a.z); errors++; end
            if (a.inten !== e.inten)
            begin
                $error("intensity exp %h got %h", e.inten, a.inten);
                errors++;
            end
            if (a.curv !== e.curv)
            begin
                $error("curvature exp %0d got %0d", e.curv, a.curv);
                errors++;
            end
            if (a.last !== e.last)
            begin
                $error("out_last exp %0d got %0d", e.last, a.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_ready;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic [31:0] time_offset = 0, frame_end_offset = 0;
    logic [7:0] scan_line = 0, reflect = 0;
    logic cloud_last = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] out_x, out_y, out_z;
    logic [31:0] intensity;
    logic [15:0] curvature;
    logic out_last;

    lidar_point_rigid_transform_unit u_dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    point_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 0;
    int stall_cycles = 0;

    // receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_point('{out_x, out_y, out_z, intensity, curvature, out_last});
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
        if (stall_cycles > 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_point(point_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        pos_x <= p.x;
        pos_y <= p.y;
        pos_z <= p.z;
        time_offset <= p.toff;
        scan_line <= p.line;
        reflect <= p.refl;
        frame_end_offset <= p.tend;
        cloud_last <= p.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_point(p);
    endtask

    task automatic stop_sending();
        in_valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(200000)) - 100000);
            2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(20000000)) - 10000000);
        endcase
    endfunction

    function automatic point_in_t rand_point();
        point_in_t p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        p.tend = ($urandom_range(9) == 0) ? 0 :
                 ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000000);
        p.toff = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000000);
        p.line = 8'($urandom);
        p.refl = 8'($urandom);
        p.last = 1'($urandom);
        return p;
    endfunction

    task automatic random_pose();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_TRANS_X, rand_coord());
        write_reg(REG_TRANS_Y, rand_coord());
        write_reg(REG_TRANS_Z, rand_coord());
        write_reg(REG_QUAT_W, $urandom);
        write_reg(REG_QUAT_X, $urandom);
        write_reg(REG_QUAT_Y, $urandom);
        write_reg(REG_QUAT_Z, $urandom);
    endtask

    initial
    begin
        point_in_t p;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        // directed: transform off, field extremes and curvature corners
        send_point('{32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 0, 0});
        send_point('{-1, 1, 32'sh7FFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 1, 1});
        send_point('{5, 6, 7, 32'hFFFFFFFF, 8'h80, 8'h01, 32'hFFFFFFFF, 0});
        send_point('{5, 6, 7, 100, 8'h01, 8'h80, 1000, 1});
        send_point('{5, 6, 7, 123, 8'h7F, 8'hFE, 0, 0});
        stop_sending();
        drain();
        // identity with extreme translation: saturation
        write_reg(REG_ENABLE, 1);
        write_reg(REG_TRANS_X, 32'h7FFFFFFF);
        write_reg(REG_TRANS_Y, 32'h80000000);
        write_reg(REG_TRANS_Z, 12345);
        send_point('{32'sh7FFFFFFF, 32'sh80000000, -5, 1, 2, 3, 4, 0});
        send_point('{-100, 100, 32'sh80000000, 1, 2, 3, 4, 1});
        stop_sending();
        drain();
        // zero quaternion keeps identity rotation
        write_reg(REG_QUAT_W, 0);
        send_point('{1000, -2000, 3000, 1, 2, 3, 4, 0});
        stop_sending();
        drain();
        // quaternion extremes
        write_reg(REG_QUAT_W, 16'h8000);
        write_reg(REG_QUAT_X, 16'h7FFF);
        write_reg(REG_QUAT_Y, 16'h8000);
        write_reg(REG_QUAT_Z, 16'h7FFF);
        send_point('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1, 2, 3, 4, 1});
        send_point('{1000000, -1000000, 77, 1, 2, 3, 4, 0});
        stop_sending();
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 70 : 0;
            recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 6 : 0;
            for (int b = 0; b < 5; b++)
            begin
                if (b == 4)
                    write_reg(REG_ENABLE, 0);
                else
                    random_pose();
                for (int k = 0; k < 66; k++)
                begin
                    // hold the receiver off so the pipe fills and stalls its input
                    if (ph == 2 && b == 1 && k == 5)
                        fork
                        begin
                            recv_hold = 1;
                            repeat (300) @(posedge clk);
                            recv_hold = 0;
                        end
                        join_none
                    if (k == 40)
                    begin
                        stop_sending();
                        while (sb.pending.size() != 0)
                            @(posedge clk);
                    end
                    send_point(rand_point());
                end
                stop_sending();
                drain();
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
